>>> hw/rtl/lea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lea_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned IP_W       = 32;
  localparam int unsigned SEQ_W      = 63;
  localparam int unsigned ROLE_W     = 2;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned NEED_W     = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned BURST_DEPTH_DEF = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOCAL   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CURSOR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLAIM   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SERVER  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLIENT  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_NEXTSEQ = 3'd5;

  // Roles
  localparam logic [ROLE_W-1:0] ROLE_INIT   = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_SERVER = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_CLIENT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_COOLDOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAIM_COOLDOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HERE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDED         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDED_HERE    = 3'd6;

  // Register reset values
  localparam logic [ID_W-1:0]   SELF_ID_RST        = 16'd0;
  localparam logic [TIME_W-1:0] SELF_COOLDOWN_RST  = 32'd2000;
  localparam logic [TIME_W-1:0] CLAIM_COOLDOWN_RST = 32'd2000;
  localparam logic [TIME_W-1:0] WINDOW_RST         = 32'd1000;
  localparam logic [TIME_W-1:0] WINDOW_HERE_RST    = 32'd1000;
  localparam logic [NEED_W-1:0] NEEDED_RST         = 5'd3;
  localparam logic [NEED_W-1:0] NEEDED_HERE_RST    = 5'd1;

  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] now_ms;
    logic              cursor_here;
    logic [ID_W-1:0]   sender_id;
    logic [IP_W-1:0]   sender_ip;
    logic [IP_W-1:0]   sender_lan;
    logic [SEQ_W-1:0]  claim_seq;
    logic [IP_W-1:0]   server_ip;
  } evt_t;

  typedef struct packed {
    logic              promote_now;
    logic              claim_follow;
    logic [SEQ_W-1:0]  seq_value;
    logic [ROLE_W-1:0] current_role;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/lea_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring of recent input times; the oldest entry is presented registered.
module lea_ring #(
  parameter int unsigned DEPTH = lea_pkg::BURST_DEPTH_DEF,
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned FILL_W = $clog2(DEPTH + 1),
  localparam int unsigned SUM_W  = PTR_W + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lea_pkg::ring_cmd_t        cmd,
  input  wire logic [lea_pkg::TIME_W-1:0] wr_time,
  output logic [FILL_W-1:0]              fill,
  output logic [lea_pkg::TIME_W-1:0]     head_time
);

  logic [lea_pkg::TIME_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [FILL_W-1:0] fill_next;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail;
  logic [SUM_W-1:0]  tail_sum;
  logic              full;

  assign full     = (fill == FILL_W'(DEPTH));
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = SUM_W'(head) + SUM_W'(fill);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                : PTR_W'(tail_sum);

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (cmd.clear) begin
      fill_next = '0;
    end else if (cmd.pop && (fill != '0)) begin
      head_next = head_inc;
      fill_next = fill - 1'b1;
    end else if (cmd.push) begin
      // full: overwrite the oldest and advance past it
      if (full) begin
        head_next = head_inc;
      end else begin
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[tail] <= wr_time;
    end
    head_time <= mem[head_next];
  end

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("ring fill above depth");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (fill == '0))
    else $error("ring not empty after clear");

  a_cmd_exclusive : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.pop, cmd.clear}))
    else $error("ring commands overlap");

endmodule

`default_nettype wire

>>> hw/rtl/leader_election_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Every event passes through EXEC and DONE before rsp_valid, except an admitted local
// input, which passes EXEC, PRUNE, STORE and DONE; PRUNE drops the stale times, at
// most BURST_DEPTH, one ring entry per cycle through the shared elapsed comparator.
// Throughput: one item at a time; the next item is taken once the result sits in
// the output register. Synchronous active-high reset sets role init, empty ring,
// sequence zero and registers to their defaults; ring contents are left as they are.
module leader_election_arbiter #(
  parameter int unsigned BURST_DEPTH = lea_pkg::BURST_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // event channel
  input  wire logic                           evt_valid,
  output logic                                evt_stall,
  input  wire lea_pkg::evt_t                  evt,
  // result channel
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output lea_pkg::rsp_t                       rsp,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [lea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lea_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned FILL_W = $clog2(BURST_DEPTH + 1);
  localparam int unsigned CMP_W  = (FILL_W > lea_pkg::NEED_W) ? FILL_W : lea_pkg::NEED_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRUNE,
    ST_STORE,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [lea_pkg::ID_W-1:0]   self_id;
  logic [lea_pkg::TIME_W-1:0] self_cooldown_ms;
  logic [lea_pkg::TIME_W-1:0] claim_cooldown_ms;
  logic [lea_pkg::TIME_W-1:0] burst_window_ms;
  logic [lea_pkg::TIME_W-1:0] burst_window_here_ms;
  logic [lea_pkg::NEED_W-1:0] burst_needed;
  logic [lea_pkg::NEED_W-1:0] burst_needed_here;

  // arbiter state
  logic [lea_pkg::ROLE_W-1:0] node_role;
  logic [lea_pkg::TIME_W-1:0] last_switch_ms;
  logic                       has_switched;
  logic                       cursor_flag;
  logic [lea_pkg::IP_W-1:0]   followed_ip;
  logic [lea_pkg::SEQ_W-1:0]  seq_high;

  // item being worked on and its partial result
  lea_pkg::evt_t              item;
  logic                       res_promote;
  logic                       res_follow;
  logic [lea_pkg::SEQ_W-1:0]  res_seq;

  // ring
  lea_pkg::ring_cmd_t         ring_cmd;
  logic [FILL_W-1:0]          ring_fill;
  logic [lea_pkg::TIME_W-1:0] ring_head_time;
  logic                       ring_empty;
  logic                       ring_full;

  // shared elapsed-time unit: (a - b) mod 2^32 against c
  logic [lea_pkg::TIME_W-1:0] cu_b;
  logic [lea_pkg::TIME_W-1:0] cu_c;
  logic [lea_pkg::TIME_W-1:0] cu_elapsed;
  logic                       cu_lt;
  logic                       cu_gt;

  logic [lea_pkg::TIME_W-1:0] window_sel;
  logic [lea_pkg::NEED_W-1:0] needed_sel;
  logic                       cool_block;
  logic                       is_server;
  logic                       is_client;
  logic [CMP_W-1:0]           fill_after;
  logic                       burst_hit;
  logic                       cursor_change;
  logic                       heartbeat;
  logic [lea_pkg::SEQ_W-1:0]  seq_inc;
  logic                       evt_take;
  logic                       rsp_free;

  assign evt_stall = (state != ST_IDLE);
  assign evt_take  = evt_valid && !evt_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign is_server  = (node_role == lea_pkg::ROLE_SERVER);
  assign is_client  = (node_role == lea_pkg::ROLE_CLIENT);
  assign window_sel = cursor_flag ? burst_window_here_ms : burst_window_ms;
  assign needed_sel = cursor_flag ? burst_needed_here : burst_needed;

  // Steer the unit: ring pruning in PRUNE, cooldown check otherwise.
  always_comb begin
    if (state == ST_PRUNE) begin
      cu_b = ring_head_time;
      cu_c = window_sel;
    end else begin
      cu_b = last_switch_ms;
      // a fresh server guards claims with the claim cooldown
      cu_c = ((item.req_type == lea_pkg::REQ_CLAIM) && is_server) ? claim_cooldown_ms
                                                                  : self_cooldown_ms;
    end
  end

  assign cu_elapsed = item.now_ms - cu_b;
  assign cu_lt      = (cu_elapsed < cu_c);
  assign cu_gt      = (cu_elapsed > cu_c);
  // never switched: cooldowns pass
  assign cool_block = has_switched && cu_lt;

  assign ring_empty = (ring_fill == '0);
  assign ring_full  = (ring_fill == FILL_W'(BURST_DEPTH));
  // count after storing the new time; a full ring drops its oldest first
  assign fill_after = ring_full ? CMP_W'(ring_fill) : CMP_W'(ring_fill) + 1'b1;
  assign burst_hit  = (fill_after >= CMP_W'(needed_sel));

  assign cursor_change = (item.cursor_here != cursor_flag);
  assign heartbeat     = is_client && ((followed_ip == item.sender_ip) ||
                                       (followed_ip == item.sender_lan));
  assign seq_inc       = (seq_high == lea_pkg::SEQ_MAX) ? seq_high : seq_high + 1'b1;

  // Ring commands from the sequencer.
  always_comb begin
    ring_cmd = '0;
    case (state)
      ST_EXEC: begin
        case (item.req_type)
          lea_pkg::REQ_CURSOR: ring_cmd.clear = cursor_change;
          lea_pkg::REQ_SERVER,
          lea_pkg::REQ_CLIENT: ring_cmd.clear = 1'b1;
          default: ring_cmd = '0;
        endcase
      end
      ST_PRUNE: ring_cmd.pop = !ring_empty && cu_gt;
      ST_STORE: begin
        ring_cmd.clear = burst_hit;
        ring_cmd.push  = !burst_hit;
      end
      default: ring_cmd = '0;
    endcase
  end

  lea_ring #(
    .DEPTH(BURST_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ring_cmd),
    .wr_time  (item.now_ms),
    .fill     (ring_fill),
    .head_time(ring_head_time)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id              <= lea_pkg::SELF_ID_RST;
      self_cooldown_ms     <= lea_pkg::SELF_COOLDOWN_RST;
      claim_cooldown_ms    <= lea_pkg::CLAIM_COOLDOWN_RST;
      burst_window_ms      <= lea_pkg::WINDOW_RST;
      burst_window_here_ms <= lea_pkg::WINDOW_HERE_RST;
      burst_needed         <= lea_pkg::NEEDED_RST;
      burst_needed_here    <= lea_pkg::NEEDED_HERE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lea_pkg::CFG_SELF_ID:        self_id              <= cfg_data[lea_pkg::ID_W-1:0];
        lea_pkg::CFG_SELF_COOLDOWN:  self_cooldown_ms     <= cfg_data[lea_pkg::TIME_W-1:0];
        lea_pkg::CFG_CLAIM_COOLDOWN: claim_cooldown_ms    <= cfg_data[lea_pkg::TIME_W-1:0];
        lea_pkg::CFG_WINDOW:         burst_window_ms      <= cfg_data[lea_pkg::TIME_W-1:0];
        lea_pkg::CFG_WINDOW_HERE:    burst_window_here_ms <= cfg_data[lea_pkg::TIME_W-1:0];
        lea_pkg::CFG_NEEDED:         burst_needed         <= cfg_data[lea_pkg::NEED_W-1:0];
        lea_pkg::CFG_NEEDED_HERE:    burst_needed_here    <= cfg_data[lea_pkg::NEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Item payload and partial result: no reset needed.
  always_ff @(posedge clk) begin
    if (evt_take) begin
      item        <= evt;
      res_promote <= 1'b0;
      res_follow  <= 1'b0;
      res_seq     <= '0;
    end else begin
      case (state)
        ST_EXEC: begin
          case (item.req_type)
            lea_pkg::REQ_CLAIM:
              res_follow <= (item.sender_id != self_id) && !cool_block && !heartbeat;
            lea_pkg::REQ_NEXTSEQ: res_seq <= seq_inc;
            default: ;
          endcase
        end
        ST_STORE: res_promote <= burst_hit;
        default: ;
      endcase
    end
  end

  // Sequencer, arbiter state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      node_role      <= lea_pkg::ROLE_INIT;
      last_switch_ms <= '0;
      has_switched   <= 1'b0;
      cursor_flag    <= 1'b0;
      followed_ip    <= '0;
      seq_high       <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      // drop the result once taken, unless the next one replaces it now
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (evt_take) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_DONE;
          case (item.req_type)
            lea_pkg::REQ_LOCAL: begin
              // a server ignores local bursts; cooldown blocks promotion
              if (!is_server && !cool_block) begin
                state <= ST_PRUNE;
              end
            end
            lea_pkg::REQ_CURSOR: cursor_flag <= item.cursor_here;
            lea_pkg::REQ_CLAIM: begin
              if (item.claim_seq > seq_high) begin
                seq_high <= item.claim_seq;
              end
            end
            lea_pkg::REQ_SERVER: begin
              node_role      <= lea_pkg::ROLE_SERVER;
              followed_ip    <= '0;
              last_switch_ms <= item.now_ms;
              has_switched   <= 1'b1;
              cursor_flag    <= 1'b0;
            end
            lea_pkg::REQ_CLIENT: begin
              node_role      <= lea_pkg::ROLE_CLIENT;
              followed_ip    <= item.server_ip;
              last_switch_ms <= item.now_ms;
              has_switched   <= 1'b1;
              cursor_flag    <= 1'b0;
            end
            lea_pkg::REQ_NEXTSEQ: seq_high <= seq_inc;
            default: ;
          endcase
        end
        ST_PRUNE: begin
          // advance past stale times from the oldest end; stop at the first fresh one
          if (ring_empty || !cu_gt) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: state <= ST_DONE;
        ST_DONE: begin
          // hold until the output register is free
          if (rsp_free) begin
            rsp_valid         <= 1'b1;
            rsp.promote_now   <= res_promote;
            rsp.claim_follow  <= res_follow;
            rsp.seq_value     <= res_seq;
            rsp.current_role  <= node_role;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Once elected or following, the node never returns to init.
  a_role_sticky : assert property (@(posedge clk) disable iff (rst)
    (node_role != lea_pkg::ROLE_INIT) |=> (node_role != lea_pkg::ROLE_INIT))
    else $error("role fell back to init");

  // The highest sequence seen only grows.
  a_seq_monotonic : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (seq_high >= $past(seq_high)))
    else $error("sequence went backwards");

  // A server never reports a promotion.
  a_no_server_promote : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.promote_now) |-> (rsp.current_role != lea_pkg::ROLE_SERVER))
    else $error("promotion reported while server");

  // The ring is only pruned while an admitted local input is in work.
  a_prune_local : assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRUNE) |-> (item.req_type == lea_pkg::REQ_LOCAL) && !is_server)
    else $error("pruning outside a local input");

endmodule

`default_nettype wire
